FILE: rtl/pwcm_pkg.sv
// ----------------------------------------------------------------------------
// pwcm_pkg: shared types and constants for the pulse width capture meter
// Field widths, register indexes, event codes and the status bundle of
// the serial arithmetic units.
// ----------------------------------------------------------------------------
package pwcm_pkg;

  // timer and state widths
  localparam int COUNTER_WIDTH    = 16;
  localparam int WRAP_COUNT_WIDTH = 16;
  localparam int PERIOD_WIDTH     = COUNTER_WIDTH + 1;
  localparam int SPAN_WIDTH       = COUNTER_WIDTH + 1;
  localparam int PROD_WIDTH       = COUNTER_WIDTH + WRAP_COUNT_WIDTH;

  // configuration and result widths
  localparam int RELOAD_WIDTH   = 16;
  localparam int TPM_WIDTH      = 20;
  localparam int CFG_DATA_WIDTH = 20;
  localparam int OVF_MS_WIDTH   = 32;
  localparam int SPAN_MS_WIDTH  = 16;

  // register reset values
  localparam logic [RELOAD_WIDTH-1:0] RELOAD_RESET = 16'hFFFF;
  localparam logic [TPM_WIDTH-1:0]    TPM_RESET    = 20'd16000;

  // serial unit step counts and counter widths
  localparam int MUL_STEPS = WRAP_COUNT_WIDTH;
  localparam int DIV_STEPS = PROD_WIDTH;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // event codes
  typedef enum logic [1:0] {
    OP_OVERFLOW = 2'd0,
    OP_FALL     = 2'd1,
    OP_RISE     = 2'd2
  } op_t;

  // register indexes
  typedef enum logic {
    CFG_RELOAD = 1'b0,
    CFG_TPM    = 1'b1
  } cfg_idx_t;

  // status of a serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } seq_stat_t;

  // one restoring division step
  typedef struct packed {
    logic [TPM_WIDTH-1:0] rem;
    logic                 q;
  } div_step_t;

endpackage

FILE: rtl/pwcm_mul.sv
// ----------------------------------------------------------------------------
// pwcm_mul: serial shift-add multiplier
// Scans the wrap count one bit per cycle, adding the shifted wrap period
// into the product. Pulses done when the last bit has been taken.
// ----------------------------------------------------------------------------
module pwcm_mul (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [pwcm_pkg::WRAP_COUNT_WIDTH-1:0]  mplier_in,
  input  logic [pwcm_pkg::PERIOD_WIDTH-1:0]      mcand_in,
  output pwcm_pkg::seq_stat_t                    stat,
  output logic [pwcm_pkg::PROD_WIDTH-1:0]        product
);

  logic [pwcm_pkg::MUL_CNT_W-1:0]        cnt;
  logic [pwcm_pkg::WRAP_COUNT_WIDTH-1:0] mplier;
  logic [pwcm_pkg::PROD_WIDTH-1:0]       mcand;

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= pwcm_pkg::MUL_CNT_W'(pwcm_pkg::MUL_STEPS);
      end else if (stat.busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == pwcm_pkg::MUL_CNT_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  // datapath: one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      product <= '0;
      mplier  <= mplier_in;
      mcand   <= pwcm_pkg::PROD_WIDTH'(mcand_in);
    end else if (stat.busy) begin
      if (mplier[0]) begin
        product <= product + mcand;
      end
      mplier <= mplier >> 1;
      mcand  <= {mcand[pwcm_pkg::PROD_WIDTH-2:0], 1'b0};
    end
  end

endmodule

FILE: rtl/pwcm_div.sv
// ----------------------------------------------------------------------------
// pwcm_div: two-lane bit-serial restoring divider
// Both lanes share one divisor and one step counter and retire one
// quotient bit each per cycle. A zero divisor yields an all-ones quotient.
// ----------------------------------------------------------------------------
module pwcm_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [pwcm_pkg::TPM_WIDTH-1:0]     den,
  input  logic [pwcm_pkg::PROD_WIDTH-1:0]    num_a,
  input  logic [pwcm_pkg::SPAN_WIDTH-1:0]    num_b,
  output pwcm_pkg::seq_stat_t                stat,
  output logic [pwcm_pkg::PROD_WIDTH-1:0]    quo_a,
  output logic [pwcm_pkg::PROD_WIDTH-1:0]    quo_b
);

  logic [pwcm_pkg::DIV_CNT_W-1:0] cnt;
  logic [pwcm_pkg::TPM_WIDTH-1:0] rem_a;
  logic [pwcm_pkg::TPM_WIDTH-1:0] rem_b;
  pwcm_pkg::div_step_t            step_a;
  pwcm_pkg::div_step_t            step_b;

  // shift one numerator bit into the remainder, subtract if it fits
  function automatic pwcm_pkg::div_step_t div_step(
    input logic [pwcm_pkg::TPM_WIDTH-1:0] rem,
    input logic [pwcm_pkg::TPM_WIDTH-1:0] d,
    input logic                           nbit
  );
    logic [pwcm_pkg::TPM_WIDTH:0] rs;
    pwcm_pkg::div_step_t          r;
    rs = {rem, nbit};
    if (rs >= {1'b0, d}) begin
      r.rem = pwcm_pkg::TPM_WIDTH'(rs - {1'b0, d});
      r.q   = 1'b1;
    end else begin
      r.rem = rs[pwcm_pkg::TPM_WIDTH-1:0];
      r.q   = 1'b0;
    end
    return r;
  endfunction

  assign step_a = div_step(rem_a, den, quo_a[pwcm_pkg::PROD_WIDTH-1]);
  assign step_b = div_step(rem_b, den, quo_b[pwcm_pkg::PROD_WIDTH-1]);

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= pwcm_pkg::DIV_CNT_W'(pwcm_pkg::DIV_STEPS);
      end else if (stat.busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == pwcm_pkg::DIV_CNT_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  // numerator registers turn into quotients as bits shift through
  always_ff @(posedge clk) begin
    if (start) begin
      rem_a <= '0;
      rem_b <= '0;
      quo_a <= num_a;
      quo_b <= pwcm_pkg::PROD_WIDTH'(num_b);
    end else if (stat.busy) begin
      rem_a <= step_a.rem;
      rem_b <= step_b.rem;
      quo_a <= {quo_a[pwcm_pkg::PROD_WIDTH-2:0], step_a.q};
      quo_b <= {quo_b[pwcm_pkg::PROD_WIDTH-2:0], step_b.q};
    end
  end

endmodule

FILE: rtl/pulse_width_capture_meter.sv
// ----------------------------------------------------------------------------
// pulse_width_capture_meter: pulse low-time meter from timer capture events
// Tracks the start capture and wrap count, and for each end-of-pulse event
// reports wrap time and partial span time in milliseconds.
//
//   channel  dir  handshake           payload
//   in       in   in_valid/in_ready   op, capture_value
//   out      out  out_valid/out_ready wrap_ms, span_ms
//   cfg      in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// Overflow and start events only update the pulse state and leave the input
// ready. An end event runs the serial multiplier (one wrap-count bit per
// cycle), then the shared two-lane divider (one quotient bit per cycle),
// then loads the output register; the next request is taken once the result
// has been loaded. A second result waits in the divider, with the input
// stalled, until the output register frees.
// Reset (rst, synchronous) clears state and loads the register defaults.
// ----------------------------------------------------------------------------
module pulse_width_capture_meter (
  input  logic                                  clk,
  input  logic                                  rst,
  // input requests
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            op,
  input  logic [pwcm_pkg::COUNTER_WIDTH-1:0]    capture_value,
  // results
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [pwcm_pkg::OVF_MS_WIDTH-1:0]     wrap_ms,
  output logic [pwcm_pkg::SPAN_MS_WIDTH-1:0]    span_ms,
  // configuration
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic                                  cfg_index,
  input  logic [pwcm_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_HOLD = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [pwcm_pkg::RELOAD_WIDTH-1:0]     reload_value;
  logic [pwcm_pkg::TPM_WIDTH-1:0]        ticks_per_ms;
  logic [pwcm_pkg::COUNTER_WIDTH-1:0]    start_capture;
  logic [pwcm_pkg::WRAP_COUNT_WIDTH-1:0] wrap_count;
  logic [pwcm_pkg::SPAN_WIDTH-1:0]       span;

  logic                                  accept;
  logic                                  rise_go;
  logic [pwcm_pkg::PERIOD_WIDTH-1:0]     period;
  logic [pwcm_pkg::SPAN_WIDTH-1:0]       wrapped_end;
  logic [pwcm_pkg::WRAP_COUNT_WIDTH-1:0] wraps_used;
  logic [pwcm_pkg::SPAN_WIDTH-1:0]       span_next;
  logic                                  out_free;

  pwcm_pkg::seq_stat_t                   mul_st;
  pwcm_pkg::seq_stat_t                   div_st;
  logic [pwcm_pkg::PROD_WIDTH-1:0]       product;
  logic [pwcm_pkg::PROD_WIDTH-1:0]       quo_a;
  logic [pwcm_pkg::PROD_WIDTH-1:0]       quo_b;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign rise_go   = accept && (pwcm_pkg::op_t'(op) == pwcm_pkg::OP_RISE);
  assign out_free  = !out_valid || out_ready;

  // end-event span and wrap count; end not above start means a wrap
  assign period      = pwcm_pkg::PERIOD_WIDTH'(reload_value) + 1'b1;
  assign wrapped_end = pwcm_pkg::SPAN_WIDTH'(capture_value) + period;
  always_comb begin
    if (capture_value > start_capture) begin
      wraps_used = wrap_count;
      span_next  = pwcm_pkg::SPAN_WIDTH'(capture_value - start_capture);
    end else begin
      wraps_used = (wrap_count == '0) ? '0 : wrap_count - 1'b1;
      if (wrapped_end >= pwcm_pkg::SPAN_WIDTH'(start_capture)) begin
        span_next = wrapped_end - pwcm_pkg::SPAN_WIDTH'(start_capture);
      end else begin
        span_next = '0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reload_value <= pwcm_pkg::RELOAD_RESET;
      ticks_per_ms <= pwcm_pkg::TPM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pwcm_pkg::cfg_idx_t'(cfg_index))
        pwcm_pkg::CFG_RELOAD: reload_value <= cfg_data[pwcm_pkg::RELOAD_WIDTH-1:0];
        pwcm_pkg::CFG_TPM:    ticks_per_ms <= cfg_data;
      endcase
    end
  end

  // pulse state: start capture and saturating wrap count
  always_ff @(posedge clk) begin
    if (rst) begin
      start_capture <= '0;
      wrap_count    <= '0;
    end else if (accept) begin
      unique case (pwcm_pkg::op_t'(op))
        pwcm_pkg::OP_OVERFLOW: begin
          if (wrap_count != '1) begin
            wrap_count <= wrap_count + 1'b1;
          end
        end
        pwcm_pkg::OP_FALL: begin
          start_capture <= capture_value;
          wrap_count    <= '0;
        end
        default: ;
      endcase
    end
  end

  // span held for the divider
  always_ff @(posedge clk) begin
    if (rise_go) begin
      span <= span_next;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (rise_go) state_next = S_MUL;
      S_MUL:  if (mul_st.done) state_next = S_DIV;
      S_DIV:  if (div_st.done) state_next = S_HOLD;
      S_HOLD: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output register with saturation of the span result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_HOLD && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_HOLD && out_free) begin
      wrap_ms <= quo_a;
      span_ms <= (|quo_b[pwcm_pkg::PROD_WIDTH-1:pwcm_pkg::SPAN_MS_WIDTH]) ?
                 '1 : quo_b[pwcm_pkg::SPAN_MS_WIDTH-1:0];
    end
  end

  pwcm_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .start     (rise_go),
    .mplier_in (wraps_used),
    .mcand_in  (period),
    .stat      (mul_st),
    .product   (product)
  );

  pwcm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (mul_st.done),
    .den   (ticks_per_ms),
    .num_a (product),
    .num_b (span),
    .stat  (div_st),
    .quo_a (quo_a),
    .quo_b (quo_b)
  );

  // checks
  a_idle_units_free: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !mul_st.busy && !div_st.busy)
    else $error("arithmetic unit busy while accepting requests");

  a_mul_feeds_div: assert property (@(posedge clk) disable iff (rst)
    mul_st.done |=> div_st.busy && state == S_DIV)
    else $error("divider not started after multiply");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> state == S_DIV)
    else $error("divider finished outside divide phase");

  a_hold_loads: assert property (@(posedge clk) disable iff (rst)
    state == S_HOLD && out_free |=> out_valid && state == S_IDLE)
    else $error("result not loaded into output register");

  a_wrap_monotonic: assert property (@(posedge clk) disable iff (rst)
    accept && pwcm_pkg::op_t'(op) == pwcm_pkg::OP_OVERFLOW
      |=> wrap_count >= $past(wrap_count))
    else $error("wrap count went down on overflow");

endmodule
